// ===== rtl/core/heater_power_integral_loop_defines.svh =====
// Assertion macros for the heater power integral loop.
`ifndef HEATER_POWER_INTEGRAL_LOOP_DEFINES_SVH
`define HEATER_POWER_INTEGRAL_LOOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HPIL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define HPIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hpil_pkg.sv =====
// Shared types, codes and constants of the heater power integral loop.
`default_nettype none

package hpil_pkg;

    localparam int HEATER_SLOTS_DEF = 2;

    localparam int OP_W         = 2;
    localparam int HEATER_IDX_W = 3;
    localparam int POWER_W      = 16;
    localparam int ELAPSED_W    = 16;
    localparam int DUTY_W       = 16;
    localparam int PULSE_W      = 32;
    localparam int MODE_W       = 2;

    localparam int IGAIN_W      = 24;
    localparam int FFGAIN_W     = 16;
    localparam int PERIOD_W     = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam int MUL_A_W      = 32;
    localparam int MUL_B_W      = 16;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

    localparam logic [OP_W-1:0] OP_SERVICE       = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_DEMAND    = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_INTERLOCK = 2'd2;
    localparam logic [OP_W-1:0] OP_ALL_OFF       = 2'd3;

    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FF   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD       = 2'd2;

    localparam logic [IGAIN_W-1:0]  IGAIN_RST  = 24'd25166;
    localparam logic [FFGAIN_W-1:0] FFGAIN_RST = 16'd655;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd65535;

    // integral step is gain*err*elapsed >> 26
    localparam int IGAIN_SHIFT = 26;

    typedef struct packed {
        logic [IGAIN_W-1:0]  integral_gain;
        logic [FFGAIN_W-1:0] feedforward_gain;
        logic [PERIOD_W-1:0] pwm_period;
    } hpil_cfg_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } hpil_mul_req_t;

    typedef struct packed {
        logic busy;
        logic armed;
    } hpil_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/hpil_cmd_if.sv =====
// Input item channel: valid/ready handshake with the command payload.
`default_nettype none

interface hpil_cmd_if;
    import hpil_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [HEATER_IDX_W-1:0] heater_index;
    logic [POWER_W-1:0]      demand_power;
    logic [POWER_W-1:0]      measured_power;
    logic                    measurement_valid;
    logic [ELAPSED_W-1:0]    elapsed_time;
    logic                    arm_value;

    modport source (
        output valid, operation, heater_index, demand_power, measured_power,
               measurement_valid, elapsed_time, arm_value,
        input  ready
    );

    modport sink (
        input  valid, operation, heater_index, demand_power, measured_power,
               measurement_valid, elapsed_time, arm_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/hpil_rpt_if.sv =====
// Result channel: valid/ready handshake with the heater drive report.
`default_nettype none

interface hpil_rpt_if;
    import hpil_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [HEATER_IDX_W-1:0] heater_slot;
    logic [DUTY_W-1:0]       duty_value;
    logic [PULSE_W-1:0]      pulse_width;
    logic [MODE_W-1:0]       drive_mode;
    logic                    last_of_run;

    modport source (
        output valid, heater_slot, duty_value, pulse_width, drive_mode, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, heater_slot, duty_value, pulse_width, drive_mode, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/hpil_mul.sv =====
// Shared 32x16 multiplier with registered product.
`default_nettype none

module hpil_mul (
    input  wire logic                    clk,
    input  wire hpil_pkg::hpil_mul_req_t req,
    output logic [hpil_pkg::MUL_P_W-1:0] prod
);
    import hpil_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;
    logic [MUL_P_W-1:0] prod_next;

    always_comb
    begin
        prod_next = {{MUL_B_W{1'b0}}, req.a} * {{MUL_A_W{1'b0}}, req.b};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hpil_ctrl.sv =====
// Sequencer, heater state and result register of the heater power loop.
`default_nettype none

module hpil_ctrl #(
    parameter int SLOTS = hpil_pkg::HEATER_SLOTS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire hpil_pkg::hpil_cfg_t     cfg,
    hpil_cmd_if.sink                     cmd,
    hpil_rpt_if.source                   rpt,
    output hpil_pkg::hpil_mul_req_t      mul_req,
    input  wire logic [hpil_pkg::MUL_P_W-1:0] mul_prod,
    output hpil_pkg::hpil_status_t       status
);
    import hpil_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [HEATER_IDX_W:0] SLOTS_CMP = (HEATER_IDX_W + 1)'(SLOTS);
    localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam int SUM_W  = 56;
    localparam int STEP_W = SUM_W + 1 - IGAIN_SHIFT;
    localparam logic [SUM_W:0] ROUND_ADD = (SUM_W + 1)'((64'd1 << IGAIN_SHIFT) - 64'd1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LP1  = 4'd1;
    localparam logic [3:0] ST_LP2  = 4'd2;
    localparam logic [3:0] ST_LP3  = 4'd3;
    localparam logic [3:0] ST_LP4  = 4'd4;
    localparam logic [3:0] ST_FF1  = 4'd5;
    localparam logic [3:0] ST_FF2  = 4'd6;
    localparam logic [3:0] ST_PW   = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;
    localparam logic [3:0] ST_CLR  = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic                   armed_reg, armed_next;
    logic [DUTY_W-1:0]      duty_store_reg   [SLOTS];
    logic [DUTY_W-1:0]      duty_store_next  [SLOTS];
    logic [POWER_W-1:0]     demand_store_reg [SLOTS];
    logic [POWER_W-1:0]     demand_store_next[SLOTS];
    logic [SLOT_W-1:0]      cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [POWER_W-1:0]     meas_reg, meas_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic                   neg_reg, neg_next;
    logic [7:0]             p1hi_reg, p1hi_next;
    logic [MUL_P_W-1:0]     acc_reg, acc_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;

    logic [HEATER_IDX_W-1:0] out_slot_reg, out_slot_next;
    logic [DUTY_W-1:0]       out_duty_reg, out_duty_next;
    logic [PULSE_W-1:0]      out_pulse_reg, out_pulse_next;
    logic [MODE_W-1:0]       out_mode_reg, out_mode_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    idx_ok;
    logic [SLOT_W-1:0]       cmd_slot;
    logic [POWER_W-1:0]      dem_cur;
    logic [POWER_W-1:0]      err_mag;
    logic [SUM_W-1:0]        prod_full;
    logic [SUM_W:0]          prod_rnd;
    logic [STEP_W-1:0]       step;
    logic [DUTY_W-1:0]       duty_cur;
    logic [STEP_W-1:0]       duty_diff;
    logic [STEP_W:0]         duty_sum;
    logic [DUTY_W-1:0]       loop_duty;
    logic [DUTY_W-1:0]       ff_duty;

    assign out_free = !out_valid_reg || rpt.ready;
    assign idx_ok   = ({1'b0, cmd.heater_index} < SLOTS_CMP);
    assign cmd_slot = cmd.heater_index[SLOT_W-1:0];
    assign dem_cur  = demand_store_reg[slot_reg];
    assign duty_cur = duty_store_reg[slot_reg];
    assign err_mag  = (meas_reg > dem_cur) ? (meas_reg - dem_cur) : (dem_cur - meas_reg);

    // 56-bit product = low partial + (high partial << 32)
    assign prod_full = {{(SUM_W - MUL_P_W){1'b0}}, acc_reg}
                     + {mul_prod[SUM_W-33:0], 32'd0};
    assign prod_rnd  = {1'b0, prod_full} + (neg_reg ? ROUND_ADD : '0);
    assign step      = prod_rnd[SUM_W:IGAIN_SHIFT];
    assign duty_diff = STEP_W'(duty_cur) - step;
    assign duty_sum  = (STEP_W + 1)'(duty_cur) + (STEP_W + 1)'(step);

    always_comb
    begin
        if (neg_reg) begin
            loop_duty = (step > STEP_W'(duty_cur)) ? '0 : duty_diff[DUTY_W-1:0];
        end
        else begin
            loop_duty = (duty_sum[STEP_W:DUTY_W] != '0) ? '1 : duty_sum[DUTY_W-1:0];
        end
    end

    assign ff_duty = (mul_prod[31:24] != 8'd0) ? '1 : mul_prod[23:8];

    always_comb
    begin
        state_next        = state_reg;
        armed_next        = armed_reg;
        duty_store_next   = duty_store_reg;
        demand_store_next = demand_store_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && !rpt.ready;
        slot_next         = slot_reg;
        meas_next         = meas_reg;
        elapsed_next      = elapsed_reg;
        neg_next          = neg_reg;
        p1hi_next         = p1hi_reg;
        acc_next          = acc_reg;
        duty_next         = duty_reg;
        mode_next         = mode_reg;
        out_slot_next     = out_slot_reg;
        out_duty_next     = out_duty_reg;
        out_pulse_next    = out_pulse_reg;
        out_mode_next     = out_mode_reg;
        out_last_next     = out_last_reg;
        mul_req.a         = cfg.pwm_period;
        mul_req.b         = duty_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid) begin
                    unique case (cmd.operation)
                        OP_SET_DEMAND:
                        begin
                            if (idx_ok) begin
                                demand_store_next[cmd_slot] = cmd.demand_power;
                            end
                        end
                        OP_SET_INTERLOCK:
                        begin
                            if (cmd.arm_value != armed_reg) begin
                                armed_next = cmd.arm_value;
                                if (!cmd.arm_value) begin
                                    for (int i = 0; i < SLOTS; i++) begin
                                        duty_store_next[i]   = '0;
                                        demand_store_next[i] = '0;
                                    end
                                    cnt_next   = '0;
                                    state_next = ST_CLR;
                                end
                            end
                        end
                        OP_ALL_OFF:
                        begin
                            for (int i = 0; i < SLOTS; i++) begin
                                duty_store_next[i]   = '0;
                                demand_store_next[i] = '0;
                            end
                            cnt_next   = '0;
                            state_next = ST_CLR;
                        end
                        OP_SERVICE:
                        begin
                            if (idx_ok) begin
                                slot_next    = cmd_slot;
                                meas_next    = cmd.measured_power;
                                elapsed_next = cmd.elapsed_time;
                                if (!armed_reg || demand_store_reg[cmd_slot] == '0) begin
                                    duty_next                 = '0;
                                    duty_store_next[cmd_slot] = '0;
                                    mode_next                 = MODE_OFF;
                                    state_next                = ST_PW;
                                end
                                else if (!cmd.measurement_valid) begin
                                    state_next = ST_FF1;
                                end
                                else begin
                                    state_next = ST_LP1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LP1:
            begin
                neg_next   = (meas_reg > dem_cur);
                mul_req.a  = {{(MUL_A_W - IGAIN_W){1'b0}}, cfg.integral_gain};
                mul_req.b  = err_mag;
                state_next = ST_LP2;
            end
            ST_LP2:
            begin
                p1hi_next  = mul_prod[39:32];
                mul_req.a  = mul_prod[31:0];
                mul_req.b  = elapsed_reg;
                state_next = ST_LP3;
            end
            ST_LP3:
            begin
                acc_next   = mul_prod;
                mul_req.a  = {{(MUL_A_W - 8){1'b0}}, p1hi_reg};
                mul_req.b  = elapsed_reg;
                state_next = ST_LP4;
            end
            ST_LP4:
            begin
                duty_next                 = loop_duty;
                duty_store_next[slot_reg] = loop_duty;
                mode_next                 = MODE_LOOP;
                state_next                = ST_PW;
            end
            ST_FF1:
            begin
                mul_req.a  = {{(MUL_A_W - FFGAIN_W){1'b0}}, cfg.feedforward_gain};
                mul_req.b  = dem_cur;
                state_next = ST_FF2;
            end
            ST_FF2:
            begin
                duty_next                 = ff_duty;
                duty_store_next[slot_reg] = ff_duty;
                mode_next                 = MODE_FF;
                state_next                = ST_PW;
            end
            ST_PW:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_slot_next  = HEATER_IDX_W'(slot_reg);
                    out_duty_next  = duty_reg;
                    out_pulse_next = mul_prod[MUL_P_W-1:16];
                    out_mode_next  = mode_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_slot_next  = HEATER_IDX_W'(cnt_reg);
                    out_duty_next  = '0;
                    out_pulse_next = '0;
                    out_mode_next  = MODE_OFF;
                    out_last_next  = (cnt_reg == LAST_SLOT);
                    if (cnt_reg == LAST_SLOT) begin
                        state_next = ST_IDLE;
                    end
                    else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            armed_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                duty_store_reg[i]   <= '0;
                demand_store_reg[i] <= '0;
            end
        end
        else begin
            state_reg        <= state_next;
            armed_reg        <= armed_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
            duty_store_reg   <= duty_store_next;
            demand_store_reg <= demand_store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        meas_reg      <= meas_next;
        elapsed_reg   <= elapsed_next;
        neg_reg       <= neg_next;
        p1hi_reg      <= p1hi_next;
        acc_reg       <= acc_next;
        duty_reg      <= duty_next;
        mode_reg      <= mode_next;
        out_slot_reg  <= out_slot_next;
        out_duty_reg  <= out_duty_next;
        out_pulse_reg <= out_pulse_next;
        out_mode_reg  <= out_mode_next;
        out_last_reg  <= out_last_next;
    end

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign rpt.valid       = out_valid_reg;
    assign rpt.heater_slot = out_slot_reg;
    assign rpt.duty_value  = out_duty_reg;
    assign rpt.pulse_width = out_pulse_reg;
    assign rpt.drive_mode  = out_mode_reg;
    assign rpt.last_of_run = out_last_reg;

    assign status.busy  = (state_reg != ST_IDLE);
    assign status.armed = armed_reg;

endmodule

`default_nettype wire

// ===== rtl/core/heater_power_integral_loop.sv =====
// Top level of the per-heater PWM power loop: config registers, sequencer, multiplier.
// Set-demand and arming transfers give no result.
// Service: off (PW, OUT), feedforward (FF1, FF2, PW, OUT) or closed loop (LP1-LP4, PW, OUT); the result is
// registered and ready rises again in the same cycle that it turns valid: one item at a time on one 32x16 multiplier.
// Disarm and all-off: one result per heater slot per cycle; a stalled result holds the sequencer.
// Reset clears demands, duties and interlock, and loads the register defaults.
`default_nettype none
`include "heater_power_integral_loop_defines.svh"

module heater_power_integral_loop #(
    parameter int HEATER_SLOTS = hpil_pkg::HEATER_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [hpil_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hpil_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    hpil_cmd_if.sink                           cmd,
    hpil_rpt_if.source                         rpt
);
    import hpil_pkg::*;

    hpil_cfg_t          cfg_reg, cfg_next;
    hpil_mul_req_t      mul_req;
    logic [MUL_P_W-1:0] mul_prod;
    hpil_status_t       status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_INTEGRAL_GAIN:    cfg_next.integral_gain    = cfg_wr_data[IGAIN_W-1:0];
                REG_FEEDFORWARD_GAIN: cfg_next.feedforward_gain = cfg_wr_data[FFGAIN_W-1:0];
                REG_PWM_PERIOD:       cfg_next.pwm_period       = cfg_wr_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.integral_gain    <= IGAIN_RST;
            cfg_reg.feedforward_gain <= FFGAIN_RST;
            cfg_reg.pwm_period       <= PERIOD_RST;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    hpil_ctrl #(
        .SLOTS(HEATER_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .rpt      (rpt),
        .mul_req  (mul_req),
        .mul_prod (mul_prod),
        .status   (status)
    );

    hpil_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    `HPIL_ASSERT_IMP(a_off_is_zero, rpt.valid && rpt.drive_mode == MODE_OFF, rpt.duty_value == '0 && rpt.pulse_width == '0, "off report with nonzero drive")
    `HPIL_ASSERT_NEXT(a_disarm_clears, cmd.valid && cmd.ready && cmd.operation == OP_SET_INTERLOCK && !cmd.arm_value, !status.armed, "interlock still armed after disarm transfer")
    `HPIL_ASSERT_NEXT(a_alloff_busy, cmd.valid && cmd.ready && cmd.operation == OP_ALL_OFF, status.busy && !cmd.ready, "all-off transfer did not start clear run")
    `HPIL_ASSERT_IMP(a_ready_idle, cmd.ready, !status.busy, "ready while sequencer busy")

endmodule

`default_nettype wire
